FILE: rtl/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

   localparam logic [2:0] CMD_INIT  = 3'd0;
   localparam logic [2:0] CMD_ALLOC = 3'd1;
   localparam logic [2:0] CMD_FREE  = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_WRITE = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   localparam logic [7:0] USED_BIT  = 8'h80;
   localparam logic [7:0] MAX_REQ   = 8'd127;
   localparam int         MAX_BLOCK = 128;

   localparam logic CSR_IDX_ARENA_SIZE = 1'b0;

   typedef struct packed {
      logic [2:0] cmd;
      logic [9:0] addr;
      logic [7:0] alloc_size;
      logic [7:0] access_length;
      logic [6:0] byte_offset;
      logic [7:0] write_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] result_addr;
      logic [7:0] read_byte;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_INIT_START,
      DP_INIT_WR,
      DP_RD_SCAN,
      DP_ALLOC_STEP,
      DP_ALLOC_HDR,
      DP_ALLOC_SPLIT,
      DP_FIND_STEP,
      DP_FREE_WR,
      DP_RD_POS,
      DP_RD_CAP,
      DP_WR_POS,
      DP_SET_ST
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] st;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       formatted;
      logic       addr_ge_lim;
      logic       asz_big;
      logic       alen_big;
      logic       scan_done;
      logic       nx_over;
      logic       used;
      logic       fit;
      logic       nx_le_addr;
      logic       acc_bad;
   } dp_stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INIT_WR,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_ALLOC_HDR,
      S_ALLOC_SPLIT,
      S_FIND_RD,
      S_FIND_CHK,
      S_FREE_WR,
      S_RD_POS,
      S_RD_WAIT,
      S_WR_POS,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/first_fit_byte_arena_allocator.sv
// Init writes headers across the arena up to limit, limit being arena_size saturated to
// ARENA_BYTES; rejects found at dispatch go straight to the result; alloc, free, read and
// write otherwise walk the block headers, a read state and a check state per header.
// Throughput: one item at a time; the next transfer is taken in the cycle after the result
// register loads, and a stalled result holds the input off.
// Reset: synchronous, active high; the arena is unformatted until an init.
`default_nettype none
module first_fit_byte_arena_allocator #(
   parameter int ARENA_BYTES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffba_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffba_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [10:0] arena_size_ff, arena_size_in;
   ffba_pkg::dp_cmd_type  dp_cmd;
   ffba_pkg::dp_stat_type dp_stat;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ffba_pkg::CSR_IDX_ARENA_SIZE) ?
                       {21'd0, arena_size_ff} : 32'd0;

   always_comb begin
      arena_size_in = arena_size_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[2] == ffba_pkg::CSR_IDX_ARENA_SIZE) begin
         arena_size_in = csr_pwdata[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_size_ff <= 11'd1024;
      end else begin
         arena_size_ff <= arena_size_in;
      end
   end

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   ffba_dp #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .req_payload (req_payload),
      .arena_size  (arena_size_ff),
      .dp_stat     (dp_stat),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

FILE: rtl/ffba_dp.sv
`default_nettype none
module ffba_dp #(
   parameter int ARENA_BYTES = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffba_pkg::dp_cmd_type dp_cmd,
   input  wire ffba_pkg::req_type    req_payload,
   input  wire logic [10:0]          arena_size,
   output ffba_pkg::dp_stat_type     dp_stat,
   output ffba_pkg::rsp_type         rsp_payload
);

   localparam int AW = (ARENA_BYTES > 1) ? $clog2(ARENA_BYTES) : 1;
   localparam int PW = (AW + 2 > 12) ? AW + 2 : 12;

   logic [7:0] mem [ARENA_BYTES];

   ffba_pkg::req_type rq_ff;
   ffba_pkg::rsp_type out_ff;
   logic [PW-1:0] limit_ff, limit_in;
   logic          formatted_ff, formatted_in;
   logic [PW-1:0] scan_ff, scan_in;
   logic [PW-1:0] start_ff, start_in;
   logic [8:0]    total_ff, total_in;
   logic [7:0]    mem_q_ff;
   logic [1:0]    st_ff, st_in;
   logic [9:0]    res_ff, res_in;
   logic [7:0]    rd_ff, rd_in;

   logic [PW-1:0] nx, addr_w, pos, h, lim_new, left;
   logic [8:0]    total_new, remain;
   logic          fit;
   logic [6:0]    hdr_cnt;
   logic          mem_we, mem_re;
   logic [PW-1:0] mem_a;
   logic [7:0]    mem_wd;

   assign nx        = scan_ff + PW'(mem_q_ff[6:0]) + PW'(1);
   assign addr_w    = PW'(rq_ff.addr);
   assign pos       = addr_w + PW'(rq_ff.byte_offset);
   assign total_new = total_ff + 9'(mem_q_ff[6:0]) + 9'd1;
   assign fit       = total_new > {1'b0, rq_ff.alloc_size};
   assign remain    = total_ff - {1'b0, rq_ff.alloc_size} - 9'd1;
   assign h         = start_ff + PW'(rq_ff.alloc_size) + PW'(1);
   assign lim_new   = (PW'(arena_size) > PW'(ARENA_BYTES)) ? PW'(ARENA_BYTES)
                                                          : PW'(arena_size);
   assign left      = limit_ff - scan_ff;
   assign hdr_cnt   = (left > PW'(ffba_pkg::MAX_BLOCK)) ? 7'd127 : left[6:0] - 7'd1;

   always_comb begin
      dp_stat.cmd         = rq_ff.cmd;
      dp_stat.formatted   = formatted_ff;
      dp_stat.addr_ge_lim = addr_w >= limit_ff;
      dp_stat.asz_big     = rq_ff.alloc_size > ffba_pkg::MAX_REQ;
      dp_stat.alen_big    = rq_ff.access_length > ffba_pkg::MAX_REQ;
      dp_stat.scan_done   = scan_ff >= limit_ff;
      dp_stat.nx_over     = nx > limit_ff;
      dp_stat.used        = mem_q_ff[7];
      dp_stat.fit         = fit;
      dp_stat.nx_le_addr  = nx <= addr_w;
      dp_stat.acc_bad     = ({1'b0, rq_ff.byte_offset} >= rq_ff.access_length) ||
                            (pos >= nx) || (pos >= limit_ff);
   end

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_a  = scan_ff;
      mem_wd = 8'd0;
      case (dp_cmd.op)
         ffba_pkg::DP_INIT_WR: begin
            mem_we = 1'b1;
            mem_wd = (scan_ff[6:0] == 7'd0) ? {1'b0, hdr_cnt} : 8'd0;
         end
         ffba_pkg::DP_RD_SCAN: begin
            mem_re = 1'b1;
         end
         ffba_pkg::DP_ALLOC_HDR: begin
            mem_we = 1'b1;
            mem_a  = start_ff;
            mem_wd = ffba_pkg::USED_BIT | {1'b0, rq_ff.alloc_size[6:0]};
         end
         ffba_pkg::DP_ALLOC_SPLIT: begin
            mem_we = (remain != 9'd0) && (h < limit_ff);
            mem_a  = h;
            mem_wd = {1'b0, remain[6:0] - 7'd1};
         end
         ffba_pkg::DP_FREE_WR: begin
            mem_we = 1'b1;
            mem_wd = {1'b0, mem_q_ff[6:0]};
         end
         ffba_pkg::DP_RD_POS: begin
            mem_re = 1'b1;
            mem_a  = pos;
         end
         ffba_pkg::DP_WR_POS: begin
            mem_we = 1'b1;
            mem_a  = pos;
            mem_wd = rq_ff.write_byte;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_a[AW-1:0]] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_a[AW-1:0]];
      end
   end

   always_comb begin
      limit_in     = limit_ff;
      formatted_in = formatted_ff;
      scan_in      = scan_ff;
      start_in     = start_ff;
      total_in     = total_ff;
      st_in        = st_ff;
      res_in       = res_ff;
      rd_in        = rd_ff;
      case (dp_cmd.op)
         ffba_pkg::DP_LOAD: begin
            scan_in  = '0;
            start_in = '0;
            total_in = '0;
            st_in    = ffba_pkg::ST_OK;
            res_in   = '0;
            rd_in    = '0;
         end
         ffba_pkg::DP_INIT_START: begin
            limit_in     = lim_new;
            formatted_in = 1'b1;
            scan_in      = '0;
         end
         ffba_pkg::DP_INIT_WR: begin
            scan_in = scan_ff + PW'(1);
         end
         ffba_pkg::DP_ALLOC_STEP: begin
            if (mem_q_ff[7]) begin
               total_in = '0;
               scan_in  = nx;
               start_in = nx;
            end else begin
               total_in = total_new;
               if (!fit) begin
                  scan_in = nx;
               end
            end
         end
         ffba_pkg::DP_ALLOC_HDR: begin
            res_in = 10'(start_ff + PW'(1));
         end
         ffba_pkg::DP_FIND_STEP: begin
            scan_in = nx;
         end
         ffba_pkg::DP_RD_CAP: begin
            rd_in = mem_q_ff;
         end
         ffba_pkg::DP_SET_ST: begin
            st_in = dp_cmd.st;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         formatted_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         formatted_ff <= formatted_in;
      end
      scan_ff  <= scan_in;
      start_ff <= start_in;
      total_ff <= total_in;
      st_ff    <= st_in;
      res_ff   <= res_in;
      rd_ff    <= rd_in;
      if (dp_cmd.op == ffba_pkg::DP_LOAD) begin
         rq_ff <= req_payload;
      end
      if (dp_cmd.load_out) begin
         out_ff.status      <= st_ff;
         out_ff.result_addr <= res_ff;
         out_ff.read_byte   <= rd_ff;
      end
   end

   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

FILE: rtl/ffba_ctrl.sv
`default_nettype none
module ffba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire ffba_pkg::dp_stat_type dp_stat,
   output ffba_pkg::dp_cmd_type       dp_cmd
);

   ffba_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ffba_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffba_pkg::S_IDLE: begin
            if (req_valid) state_in = ffba_pkg::S_DISPATCH;
         end
         ffba_pkg::S_DISPATCH: begin
            case (dp_stat.cmd)
               ffba_pkg::CMD_INIT: state_in = ffba_pkg::S_INIT_WR;
               ffba_pkg::CMD_ALLOC: begin
                  if (dp_stat.asz_big || !dp_stat.formatted) state_in = ffba_pkg::S_DONE;
                  else state_in = ffba_pkg::S_ALLOC_RD;
               end
               ffba_pkg::CMD_FREE: begin
                  if (!dp_stat.formatted || dp_stat.addr_ge_lim) state_in = ffba_pkg::S_DONE;
                  else state_in = ffba_pkg::S_FIND_RD;
               end
               ffba_pkg::CMD_READ, ffba_pkg::CMD_WRITE: begin
                  if (dp_stat.alen_big || !dp_stat.formatted || dp_stat.addr_ge_lim) begin
                     state_in = ffba_pkg::S_DONE;
                  end else begin
                     state_in = ffba_pkg::S_FIND_RD;
                  end
               end
               default: state_in = ffba_pkg::S_DONE;
            endcase
         end
         ffba_pkg::S_INIT_WR: begin
            if (dp_stat.scan_done) state_in = ffba_pkg::S_DONE;
         end
         ffba_pkg::S_ALLOC_RD: begin
            if (dp_stat.scan_done) state_in = ffba_pkg::S_DONE;
            else state_in = ffba_pkg::S_ALLOC_CHK;
         end
         ffba_pkg::S_ALLOC_CHK: begin
            if (dp_stat.nx_over) state_in = ffba_pkg::S_DONE;
            else if (!dp_stat.used && dp_stat.fit) state_in = ffba_pkg::S_ALLOC_HDR;
            else state_in = ffba_pkg::S_ALLOC_RD;
         end
         ffba_pkg::S_ALLOC_HDR:   state_in = ffba_pkg::S_ALLOC_SPLIT;
         ffba_pkg::S_ALLOC_SPLIT: state_in = ffba_pkg::S_DONE;
         ffba_pkg::S_FIND_RD: begin
            if (dp_stat.scan_done) state_in = ffba_pkg::S_DONE;
            else state_in = ffba_pkg::S_FIND_CHK;
         end
         ffba_pkg::S_FIND_CHK: begin
            if (dp_stat.nx_le_addr) state_in = ffba_pkg::S_FIND_RD;
            else if (dp_stat.cmd == ffba_pkg::CMD_FREE) state_in = ffba_pkg::S_FREE_WR;
            else if (dp_stat.acc_bad) state_in = ffba_pkg::S_DONE;
            else if (dp_stat.cmd == ffba_pkg::CMD_READ) state_in = ffba_pkg::S_RD_POS;
            else state_in = ffba_pkg::S_WR_POS;
         end
         ffba_pkg::S_FREE_WR: state_in = ffba_pkg::S_DONE;
         ffba_pkg::S_RD_POS:  state_in = ffba_pkg::S_RD_WAIT;
         ffba_pkg::S_RD_WAIT: state_in = ffba_pkg::S_DONE;
         ffba_pkg::S_WR_POS:  state_in = ffba_pkg::S_DONE;
         ffba_pkg::S_DONE: begin
            if (out_free) state_in = ffba_pkg::S_IDLE;
         end
         default: state_in = ffba_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.op       = ffba_pkg::DP_NOP;
      dp_cmd.st       = ffba_pkg::ST_OK;
      dp_cmd.load_out = 1'b0;
      unique case (state_ff)
         ffba_pkg::S_IDLE: begin
            if (req_valid) dp_cmd.op = ffba_pkg::DP_LOAD;
         end
         ffba_pkg::S_DISPATCH: begin
            case (dp_stat.cmd)
               ffba_pkg::CMD_INIT: dp_cmd.op = ffba_pkg::DP_INIT_START;
               ffba_pkg::CMD_ALLOC: begin
                  if (dp_stat.asz_big || !dp_stat.formatted) begin
                     dp_cmd.op = ffba_pkg::DP_SET_ST;
                     dp_cmd.st = ffba_pkg::ST_REJECT;
                  end
               end
               ffba_pkg::CMD_FREE: begin
                  if (!dp_stat.formatted || dp_stat.addr_ge_lim) begin
                     dp_cmd.op = ffba_pkg::DP_SET_ST;
                     dp_cmd.st = ffba_pkg::ST_RANGE;
                  end
               end
               ffba_pkg::CMD_READ, ffba_pkg::CMD_WRITE: begin
                  if (dp_stat.alen_big) begin
                     dp_cmd.op = ffba_pkg::DP_SET_ST;
                     dp_cmd.st = ffba_pkg::ST_REJECT;
                  end else if (!dp_stat.formatted || dp_stat.addr_ge_lim) begin
                     dp_cmd.op = ffba_pkg::DP_SET_ST;
                     dp_cmd.st = ffba_pkg::ST_RANGE;
                  end
               end
               default: begin
                  dp_cmd.op = ffba_pkg::DP_SET_ST;
                  dp_cmd.st = ffba_pkg::ST_REJECT;
               end
            endcase
         end
         ffba_pkg::S_INIT_WR: begin
            if (!dp_stat.scan_done) dp_cmd.op = ffba_pkg::DP_INIT_WR;
         end
         ffba_pkg::S_ALLOC_RD: begin
            if (dp_stat.scan_done) begin
               dp_cmd.op = ffba_pkg::DP_SET_ST;
               dp_cmd.st = ffba_pkg::ST_REJECT;
            end else begin
               dp_cmd.op = ffba_pkg::DP_RD_SCAN;
            end
         end
         ffba_pkg::S_ALLOC_CHK: begin
            if (dp_stat.nx_over) begin
               dp_cmd.op = ffba_pkg::DP_SET_ST;
               dp_cmd.st = ffba_pkg::ST_REJECT;
            end else begin
               dp_cmd.op = ffba_pkg::DP_ALLOC_STEP;
            end
         end
         ffba_pkg::S_ALLOC_HDR:   dp_cmd.op = ffba_pkg::DP_ALLOC_HDR;
         ffba_pkg::S_ALLOC_SPLIT: dp_cmd.op = ffba_pkg::DP_ALLOC_SPLIT;
         ffba_pkg::S_FIND_RD: begin
            if (dp_stat.scan_done) begin
               dp_cmd.op = ffba_pkg::DP_SET_ST;
               dp_cmd.st = ffba_pkg::ST_RANGE;
            end else begin
               dp_cmd.op = ffba_pkg::DP_RD_SCAN;
            end
         end
         ffba_pkg::S_FIND_CHK: begin
            if (dp_stat.nx_le_addr) begin
               dp_cmd.op = ffba_pkg::DP_FIND_STEP;
            end else if (dp_stat.cmd != ffba_pkg::CMD_FREE && dp_stat.acc_bad) begin
               dp_cmd.op = ffba_pkg::DP_SET_ST;
               dp_cmd.st = ffba_pkg::ST_RANGE;
            end
         end
         ffba_pkg::S_FREE_WR: dp_cmd.op = ffba_pkg::DP_FREE_WR;
         ffba_pkg::S_RD_POS:  dp_cmd.op = ffba_pkg::DP_RD_POS;
         ffba_pkg::S_RD_WAIT: dp_cmd.op = ffba_pkg::DP_RD_CAP;
         ffba_pkg::S_WR_POS:  dp_cmd.op = ffba_pkg::DP_WR_POS;
         ffba_pkg::S_DONE:    dp_cmd.load_out = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (dp_cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/ffba_chk.sv
`default_nettype none
module ffba_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ffba_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status != 2'd3)
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ffba_pkg::ST_OK |->
         rsp_payload.result_addr == 10'd0 && rsp_payload.read_byte == 8'd0)
      else $error("failed transfer carries data");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind first_fit_byte_arena_allocator ffba_chk u_ffba_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   class arena_tracker;
      bit [7:0]  mem [1024];
      bit        formatted;
      int        limit;
      int        arena_size;
      ffba_pkg::rsp_type expected_q[$];
      int        live_addrs[$];
      int        errors;
      int        accepted;

      function new();
         formatted  = 0;
         limit      = 0;
         arena_size = 1024;
         errors     = 0;
         accepted   = 0;
         foreach (mem[i]) mem[i] = '0;
      endfunction

      function void set_arena_size(int v);
         arena_size = v & 'h7ff;
      endfunction

      function int next_hdr(int h);
         return h + int'(mem[h][6:0]) + 1;
      endfunction

      function int block_of(int a);
         int scan;
         scan = 0;
         while (scan < limit) begin
            if (next_hdr(scan) <= a) scan = next_hdr(scan);
            else return scan;
         end
         return limit;
      endfunction

      function void format_arena();
         int left;
         int scan;
         int sz;
         foreach (mem[i]) mem[i] = '0;
         limit = (arena_size > 1024) ? 1024 : arena_size;
         left = limit;
         scan = 0;
         while (scan < limit) begin
            sz = (left < ffba_pkg::MAX_BLOCK) ? left : ffba_pkg::MAX_BLOCK;
            mem[scan] = 8'(sz - 1) & 8'h7f;
            left -= sz;
            scan += sz;
         end
         formatted = 1;
         live_addrs.delete();
      endfunction

      function logic [1:0] first_fit(int size, output logic [9:0] res);
         int scan;
         int start;
         int total;
         int nx;
         int remain;
         res = '0;
         if (size > ffba_pkg::MAX_REQ || !formatted) return ffba_pkg::ST_REJECT;
         scan = 0;
         start = 0;
         total = 0;
         while (scan < limit) begin
            nx = next_hdr(scan);
            if (nx > limit) return ffba_pkg::ST_REJECT;
            if ((mem[scan] & ffba_pkg::USED_BIT) != 0) begin
               total = 0;
               scan = nx;
               start = nx;
            end else begin
               total += int'(mem[scan][6:0]) + 1;
               if (total <= size) begin
                  scan = nx;
               end else begin
                  remain = total - size - 1;
                  mem[start] = ffba_pkg::USED_BIT | 8'(size);
                  if (remain > 0 && start + size + 1 < limit)
                     mem[start + size + 1] = 8'(remain - 1) & 8'h7f;
                  res = 10'(start + 1);
                  return ffba_pkg::ST_OK;
               end
            end
         end
         return ffba_pkg::ST_REJECT;
      endfunction

      function void apply_command(ffba_pkg::req_type r);
         ffba_pkg::rsp_type e;
         int h;
         int len;
         int pos;
         e = '0;
         accepted++;
         case (r.cmd)
            ffba_pkg::CMD_INIT: format_arena();
            ffba_pkg::CMD_ALLOC: begin
               e.status = first_fit(int'(r.alloc_size), e.result_addr);
               if (e.status == ffba_pkg::ST_OK) live_addrs.push_back(int'(e.result_addr));
            end
            ffba_pkg::CMD_FREE: begin
               if (!formatted || r.addr >= limit) begin
                  e.status = ffba_pkg::ST_RANGE;
               end else begin
                  h = block_of(int'(r.addr));
                  if (h < limit) begin
                     mem[h] = mem[h] & 8'h7f;
                     foreach (live_addrs[i])
                        if (live_addrs[i] == h + 1) begin
                           live_addrs.delete(i);
                           break;
                        end
                  end else begin
                     e.status = ffba_pkg::ST_RANGE;
                  end
               end
            end
            ffba_pkg::CMD_READ, ffba_pkg::CMD_WRITE: begin
               if (r.access_length > ffba_pkg::MAX_REQ) begin
                  e.status = ffba_pkg::ST_REJECT;
               end else if (!formatted || r.addr >= limit) begin
                  e.status = ffba_pkg::ST_RANGE;
               end else begin
                  h = block_of(int'(r.addr));
                  if (h >= limit) begin
                     e.status = ffba_pkg::ST_RANGE;
                  end else begin
                     len = next_hdr(h) - int'(r.addr);
                     if (int'(r.access_length) < len) len = int'(r.access_length);
                     pos = int'(r.addr) + int'(r.byte_offset);
                     if (int'(r.byte_offset) >= len || pos >= limit)
                        e.status = ffba_pkg::ST_RANGE;
                     else if (r.cmd == ffba_pkg::CMD_READ)
                        e.read_byte = mem[pos];
                     else
                        mem[pos] = r.write_byte;
                  end
               end
            end
            default: e.status = ffba_pkg::ST_REJECT;
         endcase
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_response(ffba_pkg::rsp_type got);
         ffba_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected transfer %h", got));
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status)
            report($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.result_addr !== e.result_addr)
            report($sformatf("result_addr %0d, want %0d", got.result_addr, e.result_addr));
         if (got.read_byte !== e.read_byte)
            report($sformatf("read_byte %h, want %h", got.read_byte, e.read_byte));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ffba_pkg::req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   ffba_pkg::rsp_type rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   arena_tracker tracker = new();
   int  burst_left;
   bit  long_hold_done;

   first_fit_byte_arena_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_response(rsp_payload);
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int mode;
      int len;
      rsp_ready = 1'b0;
      long_hold_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(1, 40);
         if (!long_hold_done && tracker.accepted > 150) begin
            long_hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            repeat (len) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= ($urandom_range(0, 7) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic csr_write(logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {ffba_pkg::CSR_IDX_ARENA_SIZE, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_arena_size(int'(value));
   endtask

   // hold valid until transfer; drop it only when a gap follows
   task automatic send(ffba_pkg::req_type r);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.apply_command(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic ffba_pkg::req_type mk(logic [2:0] c, int a, int asz, int alen, int off,
                                            int wb);
      ffba_pkg::req_type r;
      r.cmd           = c;
      r.addr          = 10'(a);
      r.alloc_size    = 8'(asz);
      r.access_length = 8'(alen);
      r.byte_offset   = 7'(off);
      r.write_byte    = 8'(wb);
      return r;
   endfunction

   function automatic int pick_addr();
      int n;
      n = tracker.live_addrs.size();
      if (n > 0 && $urandom_range(0, 9) < 7)
         return tracker.live_addrs[$urandom_range(0, n - 1)] - ($urandom_range(0, 9) == 0);
      if (tracker.limit > 0 && $urandom_range(0, 3) != 0)
         return $urandom_range(0, tracker.limit - 1);
      return $urandom_range(0, 1023);
   endfunction

   function automatic ffba_pkg::req_type random_item();
      ffba_pkg::req_type r;
      int sel;
      int alen;
      r = ffba_pkg::req_type'(($bits(ffba_pkg::req_type))'({$urandom, $urandom}));
      r.byte_offset = 7'($urandom_range(0, 126));
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         r.cmd = ffba_pkg::CMD_INIT;
      end else if (sel < 38) begin
         r.cmd = ffba_pkg::CMD_ALLOC;
         case ($urandom_range(0, 19))
            0: r.alloc_size = 8'($urandom_range(128, 255));
            1, 2, 3: r.alloc_size = 8'($urandom_range(0, 127));
            default: r.alloc_size = 8'($urandom_range(0, 20));
         endcase
      end else if (sel < 94) begin
         r.cmd = (sel < 56) ? ffba_pkg::CMD_FREE :
                 (sel < 76) ? ffba_pkg::CMD_WRITE : ffba_pkg::CMD_READ;
         r.addr = 10'(pick_addr());
         alen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 127);
         r.access_length = 8'(alen);
         if ($urandom_range(0, 4) != 0)
            r.byte_offset = 7'($urandom_range(0, (alen > 30) ? 30 : alen));
      end else begin
         r.cmd = 3'($urandom_range(5, 7));
      end
      return r;
   endfunction

   initial begin
      int sizes[$] = '{1, 2047, 0, 2, 129, 300, 1024, 1024};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_left  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(mk(ffba_pkg::CMD_ALLOC, 0, 1, 0, 0, 0));
      send(mk(ffba_pkg::CMD_FREE, 5, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_READ, 0, 0, 10, 0, 0));
      send(mk(ffba_pkg::CMD_WRITE, 1023, 0, 10, 0, 8'hff));
      send(mk(3'd5, 0, 0, 0, 0, 0));
      send(mk(3'd6, 1023, 255, 255, 127, 255));
      send(mk(3'd7, 0, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_INIT, 0, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_ALLOC, 0, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_ALLOC, 0, 127, 0, 0, 0));
      send(mk(ffba_pkg::CMD_ALLOC, 0, 128, 0, 0, 0));
      send(mk(ffba_pkg::CMD_ALLOC, 0, 255, 0, 0, 0));
      send(mk(ffba_pkg::CMD_WRITE, 3, 0, 127, 126, 8'hff));
      send(mk(ffba_pkg::CMD_WRITE, 3, 0, 127, 5, 8'ha5));
      send(mk(ffba_pkg::CMD_READ, 3, 0, 127, 5, 0));
      send(mk(ffba_pkg::CMD_READ, 3, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_READ, 3, 0, 128, 0, 0));
      send(mk(ffba_pkg::CMD_READ, 3, 0, 255, 0, 0));
      send(mk(ffba_pkg::CMD_READ, 0, 0, 1, 0, 0));
      send(mk(ffba_pkg::CMD_WRITE, 2, 0, 1, 0, 8'h00));
      send(mk(ffba_pkg::CMD_FREE, 1, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_FREE, 1, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_FREE, 1023, 0, 0, 0, 0));
      send(mk(ffba_pkg::CMD_ALLOC, 0, 126, 0, 0, 0));
      drain();

      foreach (sizes[p]) begin
         csr_write(32'(sizes[p]));
         if (p % 2 == 0) send(mk(ffba_pkg::CMD_INIT, 0, 0, 0, 0, 0));
         repeat (75) send(random_item());
         drain();
      end
      repeat (1100) @(posedge clock);

      if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
